>>> rtl/sorted_key_run_combiner_defines.svh
// assertion macros used by the run combiner back end
`ifndef SORTED_KEY_RUN_COMBINER_DEFINES_SVH
`define SORTED_KEY_RUN_COMBINER_DEFINES_SVH

`ifndef SYNTHESIS
`define SKRC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SKRC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SKRC_ASSERT_IMP(lbl, ante, cons, msg)
`define SKRC_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/skrc_pkg.sv
// types, register codes and the run filter of the run combiner
package skrc_pkg;

    typedef logic [3:0] mode_t;

    localparam mode_t MODE_MERGE    = 4'd0;
    localparam mode_t MODE_MIN      = 4'd1;
    localparam mode_t MODE_MINEXIST = 4'd2;
    localparam mode_t MODE_MAX      = 4'd3;
    localparam mode_t MODE_ADD      = 4'd4;
    localparam mode_t MODE_AND      = 4'd5;
    localparam mode_t MODE_NAND     = 4'd6;
    localparam mode_t MODE_OR       = 4'd7;
    localparam mode_t MODE_XOR      = 4'd8;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 8;

    localparam logic [CFG_INDEX_BITS-1:0] REG_MODE        = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_NUM_SOURCES = 2'd1;

    localparam logic [7:0] NUM_SOURCES_RESET = 8'd2;
    localparam logic [7:0] ITEMS_MAX         = 8'd255;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_BITS = 2;

    // control bits of one queued item
    typedef struct packed {
        logic close_prev;
        logic start;
        logic eos;
    } skrc_ctl_t;

    localparam int CTL_BITS = 3;

    function automatic logic run_passes(mode_t m, logic [7:0] items, logic [7:0] num_src);
        logic pass;
        case (m) inside
            MODE_MERGE, MODE_MINEXIST, MODE_MAX, MODE_ADD, MODE_OR: pass = 1'b1;
            MODE_MIN, MODE_AND: pass = (items == num_src);
            MODE_NAND:          pass = (items != num_src);
            MODE_XOR:           pass = items[0];
            default:            pass = 1'b0;
        endcase
        return pass;
    endfunction

endpackage

>>> rtl/sorted_key_run_combiner.sv
// top level of the sorted key run combiner
// Group-by-reduce over a key-sorted stream of (key, count) items.
// Slave channel s_*: one item per transaction, s_tlast marks the end of the
// stream. Master channel m_*: one emitted run per transaction; m_tlast marks
// the last result caused by an input item, m_tuser the final result of a
// stream. Registers mode and num_sources are written on the cfg_* channel;
// the user must write them only while the block is idle, as the block itself
// does not enforce it; cfg_ready is always high. m_tvalid is registered: a
// result passes the queue write, then the output register. Throughput: one
// item per cycle unless the queue fills or the receiver stalls, set by the
// single compare in the front end and the single accumulate in the back end;
// an item that emits two runs holds the back end until its spare slot drains,
// because the output register and its spare slot drain one result per cycle.
// A four-entry queue sits between the front and back end, so input keeps
// flowing while the receiver stalls until the queue fills; then s_tready drops.
// Reset clears the run state and the queue, sets mode to merge and
// num_sources to 2.
module sorted_key_run_combiner
    import skrc_pkg::*;
#(
    parameter int KEY_BITS   = 64,
    parameter int COUNT_BITS = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [((KEY_BITS+COUNT_BITS+7)/8)*8-1:0] s_tdata,   // key, count, zero pad
    input  logic                      s_tlast,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [((KEY_BITS+COUNT_BITS+7)/8)*8-1:0] m_tdata,   // out_key, out_count, zero pad
    output logic                      m_tlast,
    output logic                      m_tuser,   // stream_done
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int PAYLOAD_BITS = KEY_BITS + COUNT_BITS;
    localparam int TDATA_BITS   = ((PAYLOAD_BITS + 7) / 8) * 8;
    localparam int Q_BITS       = CTL_BITS + PAYLOAD_BITS;

    mode_t                 mode_reg;
    logic [7:0]            num_sources_reg;

    logic                  q_full;
    logic                  q_push;
    logic [Q_BITS-1:0]     q_wdata;
    logic                  q_valid;
    logic                  q_pop;
    logic [Q_BITS-1:0]     q_rdata;

    logic [KEY_BITS-1:0]   out_key;
    logic [COUNT_BITS-1:0] out_count;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_MERGE;
            num_sources_reg <= NUM_SOURCES_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MODE:        mode_reg        <= cfg_data[3:0];
                REG_NUM_SOURCES: num_sources_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    skrc_front #(
        .KEY_BITS   (KEY_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .key           (s_tdata[KEY_BITS-1:0]),
        .count         (s_tdata[KEY_BITS +: COUNT_BITS]),
        .end_of_stream (s_tlast),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_wdata)
    );

    skrc_queue #(
        .WIDTH (Q_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_rdata)
    );

    skrc_back #(
        .KEY_BITS   (KEY_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .mode        (mode_reg),
        .num_sources (num_sources_reg),
        .q_valid     (q_valid),
        .q_data      (q_rdata),
        .q_pop       (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_key     (out_key),
        .out_count   (out_count),
        .out_last    (m_tlast),
        .stream_done (m_tuser)
    );

    assign m_tdata = TDATA_BITS'({out_count, out_key});

endmodule

>>> rtl/skrc_front.sv
// front end: accepts items and marks run boundaries
module skrc_front
    import skrc_pkg::*;
#(
    parameter int KEY_BITS   = 64,
    parameter int COUNT_BITS = 32
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [KEY_BITS-1:0]                   key,
    input  logic [COUNT_BITS-1:0]                 count,
    input  logic                                  end_of_stream,
    input  logic                                  q_full,
    output logic                                  q_push,
    output logic [CTL_BITS+COUNT_BITS+KEY_BITS-1:0] q_data
);

    logic [KEY_BITS-1:0] run_key_reg;
    logic [KEY_BITS-1:0] run_key_next;
    logic                run_open_reg;
    logic                run_open_next;
    skrc_ctl_t           ctl;

    assign in_ready = !q_full;
    assign q_push   = in_valid && in_ready;

    always_comb
    begin
        ctl.close_prev = run_open_reg && (key != run_key_reg);
        ctl.start      = !run_open_reg || (key != run_key_reg);
        ctl.eos        = end_of_stream;
        q_data         = {ctl, count, key};
        run_key_next   = run_key_reg;
        run_open_next  = run_open_reg;
        if (q_push)
        begin
            run_key_next  = end_of_stream ? '0 : key;
            run_open_next = !end_of_stream;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_key_reg  <= '0;
            run_open_reg <= 1'b0;
        end
        else
        begin
            run_key_reg  <= run_key_next;
            run_open_reg <= run_open_next;
        end
    end

endmodule

>>> rtl/skrc_queue.sv
// short queue between the front and the back end
module skrc_queue
    import skrc_pkg::*;
#(
    parameter int WIDTH = 99
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0]          mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_BITS:0]   fill_reg;
    logic [QUEUE_PTR_BITS:0]   fill_next;

    assign full     = (fill_reg == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
    assign valid    = (fill_reg != '0);
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
            fill_next = fill_reg + 1'b1;
        else if (pop && !push)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            fill_reg <= fill_next;
        end
    end

endmodule

>>> rtl/skrc_back.sv
// back end: combines counts per run and emits filtered runs
`include "sorted_key_run_combiner_defines.svh"
module skrc_back
    import skrc_pkg::*;
#(
    parameter int KEY_BITS   = 64,
    parameter int COUNT_BITS = 32
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  mode_t                                   mode,
    input  logic [7:0]                              num_sources,
    input  logic                                    q_valid,
    input  logic [CTL_BITS+COUNT_BITS+KEY_BITS-1:0] q_data,
    output logic                                    q_pop,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [KEY_BITS-1:0]                     out_key,
    output logic [COUNT_BITS-1:0]                   out_count,
    output logic                                    out_last,
    output logic                                    stream_done
);

    logic [KEY_BITS-1:0]   in_key;
    logic [COUNT_BITS-1:0] in_count;
    skrc_ctl_t             ctl;

    logic [KEY_BITS-1:0]   run_key_reg;
    logic [COUNT_BITS-1:0] run_count_reg;
    logic [7:0]            run_items_reg;

    logic [KEY_BITS-1:0]   cur_key;
    logic [COUNT_BITS-1:0] base_count;
    logic [COUNT_BITS-1:0] count_next;
    logic [7:0]            base_items;
    logic [7:0]            items_next;
    logic                  emit_a;
    logic                  emit_b;

    logic                  out_valid_reg;
    logic [KEY_BITS-1:0]   out_key_reg;
    logic [COUNT_BITS-1:0] out_count_reg;
    logic                  out_last_reg;
    logic                  out_done_reg;

    // second result of an item waits here
    logic                  spare_valid_reg;
    logic [KEY_BITS-1:0]   spare_key_reg;
    logic [COUNT_BITS-1:0] spare_count_reg;

    assign {ctl, in_count, in_key} = q_data;

    assign q_pop = q_valid && !spare_valid_reg && (!out_valid_reg || out_ready);

    always_comb
    begin
        cur_key    = ctl.start ? in_key : run_key_reg;
        base_count = ctl.start ? '0 : run_count_reg;
        base_items = ctl.start ? '0 : run_items_reg;
        count_next = base_count;
        case (mode) inside
            MODE_MERGE, MODE_ADD:
                count_next = base_count + in_count;
            MODE_MIN, MODE_MINEXIST:
                if ((base_items == '0) || (base_count > in_count))
                    count_next = in_count;
            MODE_MAX:
                if (base_count < in_count)
                    count_next = in_count;
            MODE_AND, MODE_NAND, MODE_OR, MODE_XOR:
                count_next = COUNT_BITS'(1);
            default:
                count_next = base_count;
        endcase
        items_next = (base_items == ITEMS_MAX) ? ITEMS_MAX : base_items + 1'b1;
        emit_a = ctl.close_prev && run_passes(mode, run_items_reg, num_sources);
        emit_b = ctl.eos && run_passes(mode, items_next, num_sources);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_key_reg   <= '0;
            run_count_reg <= '0;
            run_items_reg <= '0;
        end
        else if (q_pop)
        begin
            if (ctl.eos)
            begin
                run_key_reg   <= '0;
                run_count_reg <= '0;
                run_items_reg <= '0;
            end
            else
            begin
                run_key_reg   <= cur_key;
                run_count_reg <= count_next;
                run_items_reg <= items_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            spare_valid_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            out_valid_reg   <= emit_a || emit_b;
            spare_valid_reg <= emit_a && emit_b;
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_reg   <= spare_valid_reg;
            spare_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            if (emit_a)
            begin
                out_key_reg   <= run_key_reg;
                out_count_reg <= run_count_reg;
                out_last_reg  <= !emit_b;
                out_done_reg  <= !emit_b && ctl.eos;
            end
            else
            begin
                out_key_reg   <= cur_key;
                out_count_reg <= count_next;
                out_last_reg  <= 1'b1;
                out_done_reg  <= 1'b1;
            end
            spare_key_reg   <= cur_key;
            spare_count_reg <= count_next;
        end
        else if (out_valid_reg && out_ready && spare_valid_reg)
        begin
            out_key_reg   <= spare_key_reg;
            out_count_reg <= spare_count_reg;
            out_last_reg  <= 1'b1;
            out_done_reg  <= 1'b1;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_key     = out_key_reg;
    assign out_count   = out_count_reg;
    assign out_last    = out_last_reg;
    assign stream_done = out_done_reg;

    `SKRC_ASSERT_IMP(a_spare_behind_out, spare_valid_reg, out_valid_reg, "spare without result")
    `SKRC_ASSERT_NXT(a_pair_order, q_pop && emit_a && emit_b,
        spare_valid_reg && !out_last_reg, "first of a pair marked last")
    `SKRC_ASSERT_IMP(a_done_is_last, out_valid_reg && out_done_reg, out_last_reg,
        "stream end not on last result")

endmodule
